@@ rtl/nde_pkg.sv @@
// ----------------------------------------------------------------------------
// nde_pkg
// Shared constants, types and arithmetic helpers of the edge detector.
// ----------------------------------------------------------------------------
package nde_pkg;

    localparam int LINE_WIDTH   = 640;
    localparam int FRAME_ROWS   = 480;
    localparam int MAX_DISTANCE = 4;
    localparam int STORE_ROWS   = 2 * MAX_DISTANCE;
    localparam int COL_W        = $clog2(LINE_WIDTH);
    localparam int ROW_W        = $clog2(FRAME_ROWS);
    localparam int SROW_W       = $clog2(STORE_ROWS);
    localparam int PROW_W       = (MAX_DISTANCE > 1) ? $clog2(MAX_DISTANCE) : 1;
    localparam int DIST_W       = 3;
    localparam int QUOT_W       = 21;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_DIVISOR   = 3'd1;
    localparam logic [2:0] REG_DISTANCE  = 3'd2;
    localparam logic [2:0] REG_MOTION    = 3'd3;
    localparam logic [2:0] REG_RENDER    = 3'd4;

    localparam logic [1:0] MODE_MONO     = 2'd0;
    localparam logic [1:0] MODE_COLOUR   = 2'd1;
    localparam logic [1:0] MODE_CARTOON  = 2'd2;
    localparam logic [1:0] MODE_REVERSED = 2'd3;

    typedef logic [23:0] rgb_t;

    typedef struct packed {
        logic            frame_start;
        rgb_t            pix;
        rgb_t            prev;
    } pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic             edge_found;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV
    } seq_state_t;

    function automatic logic [7:0] chan(input rgb_t p, input int k);
        return p[23-8*k -: 8];
    endfunction

endpackage

@@ rtl/nde_if.sv @@
// ----------------------------------------------------------------------------
// nde_if
// Valid/ready channel carrying one pixel or one result per transaction.
// ----------------------------------------------------------------------------
interface nde_pix_if;
    import nde_pkg::*;
    logic   valid;
    logic   ready;
    logic   frame_start;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic [7:0] prev_red;
    logic [7:0] prev_green;
    logic [7:0] prev_blue;
    modport source (output valid, frame_start, pix_red, pix_green, pix_blue,
                    prev_red, prev_green, prev_blue, input ready);
    modport sink   (input valid, frame_start, pix_red, pix_green, pix_blue,
                    prev_red, prev_green, prev_blue, output ready);
endinterface

interface nde_res_if;
    logic        valid;
    logic        ready;
    logic [8:0]  center_row;
    logic [9:0]  center_col;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        edge_found;
    modport source (output valid, center_row, center_col, out_red, out_green,
                    out_blue, edge_found, input ready);
    modport sink   (input valid, center_row, center_col, out_red, out_green,
                    out_blue, edge_found, output ready);
endinterface

@@ rtl/nde_divider.sv @@
// ----------------------------------------------------------------------------
// nde_divider
// Restoring divider for the three colour channels, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module nde_divider
    import nde_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [3*QUOT_W-1:0]      dividend,
    input  logic [7:0]               divisor,
    output logic                     done,
    output logic [3*QUOT_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [3*QUOT_W-1:0] quot_reg, quot_next;
    logic [3*8-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    always_comb
    begin
        logic [8:0] trial;
        trial     = '0;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                trial = {rem_reg[8*k +: 8], quot_reg[QUOT_W*k + QUOT_W-1]};
                if (trial >= {1'b0, divisor})
                begin
                    rem_next[8*k +: 8] = 8'(trial - {1'b0, divisor});
                    quot_next[QUOT_W*k +: QUOT_W] =
                        {quot_reg[QUOT_W*k +: QUOT_W-1], 1'b1};
                end
                else
                begin
                    rem_next[8*k +: 8] = trial[7:0];
                    quot_next[QUOT_W*k +: QUOT_W] =
                        {quot_reg[QUOT_W*k +: QUOT_W-1], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ rtl/neighbour_difference_edge_detect.sv @@
// ----------------------------------------------------------------------------
// neighbour_difference_edge_detect
// Neighbour-difference edge and motion detector for a raster RGB stream.
// ----------------------------------------------------------------------------
// A pixel transaction that yields no result is accepted and then written to
// the stores. One that yields a result is accepted, reads the centre, left,
// right and top pixels in turn through the single line-store read port, and
// then takes a compute step that also writes the stores. In colour-difference
// mode the compute step starts the bit-serial divider, and the result waits
// for it. A new pixel is taken only once a waiting result leaves, so a slow
// result consumer stalls the input. Results lag by the neighbour distance in
// rows; border pixels give none. The line stores need no clearing after reset.
module neighbour_difference_edge_detect
    import nde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    nde_pix_if.sink     pix_in,
    nde_res_if.source   res_out
);

    localparam int LS_DEPTH = STORE_ROWS * LINE_WIDTH;
    localparam int PS_DEPTH = MAX_DISTANCE * LINE_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int PS_AW    = $clog2(PS_DEPTH);

    // Configuration registers.
    logic [7:0]        thr_reg;
    logic [7:0]        div_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              mot_reg;
    logic [1:0]        mode_reg;
    logic [2:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 8'd10;
            div_reg  <= 8'd10;
            dist_reg <= 3'd1;
            mot_reg  <= 1'b0;
            mode_reg <= MODE_MONO;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_THRESHOLD: thr_reg  <= pwdata[7:0];
                REG_DIVISOR:   div_reg  <= pwdata[7:0];
                REG_DISTANCE:  dist_reg <= pwdata[2:0];
                REG_MOTION:    mot_reg  <= pwdata[0];
                REG_RENDER:    mode_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_THRESHOLD: prdata = {24'd0, thr_reg};
            REG_DIVISOR:   prdata = {24'd0, div_reg};
            REG_DISTANCE:  prdata = {29'd0, dist_reg};
            REG_MOTION:    prdata = {31'd0, mot_reg};
            REG_RENDER:    prdata = {30'd0, mode_reg};
            default:       prdata = '0;
        endcase
    end

    // Memories.
    pixel_t           pix_reg;
    rgb_t line_mem [LS_DEPTH];
    rgb_t prev_mem [PS_DEPTH];
    rgb_t ls_rdata_reg;
    rgb_t ps_rdata_reg;
    logic             ls_we, ps_we;
    logic [LS_AW-1:0] ls_raddr, ls_waddr;
    logic [PS_AW-1:0] ps_raddr, ps_waddr;

    always_ff @(posedge clk)
    begin
        if (ls_we)
            line_mem[ls_waddr] <= pix_reg.pix;
        if (ps_we)
            prev_mem[ps_waddr] <= pix_reg.prev;
        ls_rdata_reg <= line_mem[ls_raddr];
        ps_rdata_reg <= prev_mem[ps_raddr];
    end

    // Sequencer state.
    seq_state_t       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next, r_cur_reg;
    logic [COL_W-1:0] col_reg, col_next, c_cur_reg;
    logic [1:0]       rd_reg, rd_next;
    logic [2:0]       dist_eff;
    logic             due_reg;
    rgb_t             ctr_reg, lft_reg, rgt_reg;
    result_t          res_reg;
    logic             res_valid_reg;
    logic             div_start;
    logic             div_done;
    logic [3*QUOT_W-1:0] div_dividend, div_quot;
    logic [2:0]       neg_reg;
    logic             edge_reg;
    logic             pix_acc;

    always_comb
    begin
        if (dist_reg == 3'd0)
            dist_eff = 3'd1;
        else if (dist_reg > 3'(MAX_DISTANCE))
            dist_eff = 3'(MAX_DISTANCE);
        else
            dist_eff = dist_reg;
    end

    // A pixel may be taken in the cycle in which the waiting result leaves.
    assign pix_in.ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_out.ready);
    assign pix_acc      = pix_in.valid && pix_in.ready;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (pix_acc)
        begin
            if (pix_in.frame_start)
            begin
                row_next = '0;
                col_next = '0;
            end
            if (col_next == COL_W'(LINE_WIDTH - 1))
            begin
                col_next = '0;
                row_next = (row_next == ROW_W'(FRAME_ROWS - 1)) ? '0 : row_next + 1'b1;
            end
            else
                col_next = col_next + 1'b1;
        end
    end

    // Store row slot helpers.
    logic [ROW_W-1:0] crow;
    logic [ROW_W-1:0] trow;
    assign crow = r_cur_reg - ROW_W'(dist_eff);
    assign trow = r_cur_reg - ROW_W'({dist_eff, 1'b0});

    function automatic logic [LS_AW-1:0] ls_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
        return LS_AW'((r % STORE_ROWS) * LINE_WIDTH + c);
    endfunction

    always_comb
    begin
        unique case (rd_reg)
            2'd0:    ls_raddr = ls_addr(crow, c_cur_reg);
            2'd1:    ls_raddr = ls_addr(crow, c_cur_reg - COL_W'(dist_eff));
            2'd2:    ls_raddr = ls_addr(crow, c_cur_reg + COL_W'(dist_eff));
            default: ls_raddr = ls_addr(trow, c_cur_reg);
        endcase
        ps_raddr = PS_AW'((crow % MAX_DISTANCE) * LINE_WIDTH + c_cur_reg);
        ls_waddr = ls_addr(r_cur_reg, c_cur_reg);
        ps_waddr = PS_AW'((r_cur_reg % MAX_DISTANCE) * LINE_WIDTH + c_cur_reg);
    end

    // Compute on the registered reads.
    logic              edge_c;
    logic signed [10:0] sum_c[3];
    logic              res_fire;

    always_comb
    begin
        logic signed [17:0] df;
        logic        [17:0] dot;
        rgb_t               nb4[4];
        if (mot_reg)
        begin
            nb4[0] = ps_rdata_reg; nb4[1] = ps_rdata_reg;
            nb4[2] = ps_rdata_reg; nb4[3] = ps_rdata_reg;
        end
        else
        begin
            nb4[0] = lft_reg; nb4[1] = rgt_reg;
            nb4[2] = ls_rdata_reg; nb4[3] = pix_reg.pix;
        end
        edge_c = 1'b0;
        for (int k = 0; k < 3; k++)
            sum_c[k] = '0;
        for (int i = 0; i < 4; i++)
        begin
            dot = '0;
            for (int k = 0; k < 3; k++)
            begin
                df = $signed({1'b0, chan(ctr_reg, k)}) - $signed({1'b0, chan(nb4[i], k)});
                dot = dot + 18'(df * df);
                sum_c[k] = sum_c[k] + 11'(df);
            end
            if (dot > 18'(thr_reg) * 18'(thr_reg))
                edge_c = 1'b1;
        end
    end

    // Products for the colour mode; sign kept aside, magnitude divided.
    always_comb
    begin
        logic signed [19:0] prod;
        for (int k = 0; k < 3; k++)
        begin
            prod = 20'(sum_c[k]) * $signed({12'd0, thr_reg});
            div_dividend[QUOT_W*k +: QUOT_W] = prod[19] ? QUOT_W'(-prod) : QUOT_W'(prod);
        end
    end

    function automatic logic [7:0] clamp_q(input logic neg, input logic [QUOT_W-1:0] q);
        logic signed [QUOT_W+1:0] v;
        v = neg ? 23'sd127 - $signed({2'b0, q}) : 23'sd127 + $signed({2'b0, q});
        if (v < 0)
            return 8'd0;
        else if (v > 255)
            return 8'd255;
        else
            return v[7:0];
    endfunction

    function automatic logic [7:0] render(input logic [1:0] m, input logic e,
                                          input logic [7:0] p);
        unique case (m)
            MODE_MONO:    return e ? 8'd0 : 8'd255;
            MODE_CARTOON: return e ? 8'd0 : p;
            default:      return e ? p : 8'd255;
        endcase
    endfunction

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        rd_next    = rd_reg;
        unique case (state_reg)
            ST_IDLE:
                if (pix_acc)
                    state_next = ST_READ;
            ST_READ:
            begin
                if (!due_reg)
                    state_next = ST_IDLE;
                else
                begin
                    rd_next = rd_reg + 1'b1;
                    if (rd_reg == 2'd3)
                        state_next = ST_CALC;
                end
            end
            ST_CALC:
                state_next = (mode_reg == MODE_COLOUR) ? ST_DIV : ST_IDLE;
            ST_DIV:
                if (div_done)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Output-side controls.
    always_comb
    begin
        ls_we     = 1'b0;
        ps_we     = 1'b0;
        div_start = 1'b0;
        res_fire  = 1'b0;
        unique case (state_reg)
            ST_READ:
                if (!due_reg)
                begin
                    ls_we = 1'b1;
                    ps_we = 1'b1;
                end
            ST_CALC:
            begin
                ls_we = 1'b1;
                ps_we = 1'b1;
                div_start = (mode_reg == MODE_COLOUR);
                res_fire  = (mode_reg != MODE_COLOUR);
            end
            ST_DIV:
                res_fire = div_done;
            default: ;
        endcase
    end

    nde_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ((div_reg == 8'd0) ? 8'd1 : div_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Only IDLE accepts, and only once the result slot is free or freeing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_reg        <= 2'd0;
            row_reg       <= '0;
            col_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_reg    <= (state_reg == ST_IDLE) ? 2'd0 : rd_next;
            if (pix_acc)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (res_fire)
                res_valid_reg <= 1'b1;
            else if (res_out.ready)
                res_valid_reg <= 1'b0;
        end
    end

    logic [ROW_W-1:0] r_in;
    logic [COL_W-1:0] c_in;
    assign r_in = pix_in.frame_start ? '0 : row_reg;
    assign c_in = pix_in.frame_start ? '0 : col_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            pix_reg   <= {pix_in.frame_start,
                          pix_in.pix_red, pix_in.pix_green, pix_in.pix_blue,
                          pix_in.prev_red, pix_in.prev_green, pix_in.prev_blue};
            r_cur_reg <= r_in;
            c_cur_reg <= c_in;
            due_reg   <= (r_in >= ROW_W'({dist_eff, 1'b0})) && (c_in >= COL_W'(dist_eff))
                         && ({1'b0, c_in} + 11'(dist_eff) < 11'(LINE_WIDTH));
        end
        if (state_reg == ST_READ)
        begin
            unique case (rd_reg)
                2'd1:    ctr_reg <= ls_rdata_reg;
                2'd2:    lft_reg <= ls_rdata_reg;
                2'd3:    rgt_reg <= ls_rdata_reg;
                default: ;
            endcase
        end
        if (state_reg == ST_CALC)
        begin
            edge_reg <= edge_c;
            for (int k = 0; k < 3; k++)
                neg_reg[k] <= sum_c[k][10];
        end
        if (state_reg == ST_CALC && mode_reg != MODE_COLOUR)
        begin
            res_reg.center_row <= crow;
            res_reg.center_col <= c_cur_reg;
            res_reg.edge_found <= edge_c;
            res_reg.out_red    <= render(mode_reg, edge_c, chan(ctr_reg, 0));
            res_reg.out_green  <= render(mode_reg, edge_c, chan(ctr_reg, 1));
            res_reg.out_blue   <= render(mode_reg, edge_c, chan(ctr_reg, 2));
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            res_reg.center_row <= crow;
            res_reg.center_col <= c_cur_reg;
            res_reg.edge_found <= edge_reg;
            res_reg.out_red    <= clamp_q(neg_reg[0], div_quot[0 +: QUOT_W]);
            res_reg.out_green  <= clamp_q(neg_reg[1], div_quot[QUOT_W +: QUOT_W]);
            res_reg.out_blue   <= clamp_q(neg_reg[2], div_quot[2*QUOT_W +: QUOT_W]);
        end
    end

    assign res_out.valid      = res_valid_reg;
    assign res_out.center_row = res_reg.center_row;
    assign res_out.center_col = res_reg.center_col;
    assign res_out.out_red    = res_reg.out_red;
    assign res_out.out_green  = res_reg.out_green;
    assign res_out.out_blue   = res_reg.out_blue;
    assign res_out.edge_found = res_reg.edge_found;

endmodule
